/* hw/rtl/rcag_pkg.sv */
// Package for the Ricart-Agrawala node core: sizes, operation and result codes,
// and the word type passed from the front queue to the back end.
// No dependencies.
package rcag_pkg;

   localparam int NODES   = 16;
   localparam int NODE_W  = 4;     // bits of a node id, log2 of NODES
   localparam int SEQ_W   = 16;    // sequence number width
   localparam int OUTST_W = 4;     // holds NODES-1
   localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};
   localparam logic [OUTST_W-1:0] OUTST_LOAD = OUTST_W'(NODES - 1);

   // input operations
   typedef enum logic [1:0] {
      OP_LOCAL_REQ  = 2'd0,
      OP_REMOTE_REQ = 2'd1,
      OP_REMOTE_REP = 2'd2,
      OP_RELEASE    = 2'd3
   } op_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_BCAST = 2'd0,
      KIND_REPLY = 2'd1,
      KIND_GRANT = 2'd2
   } kind_type;

   // back end sequencer
   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_SCAN = 1'b1
   } back_state_type;

   // one queued word, already decoded
   typedef struct packed {
      op_type              op;
      logic [SEQ_W-1:0]    seq;
      logic [NODE_W-1:0]   node;
   } item_type;

   // front to back handshake
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

/* hw/rtl/rcag_front.sv */
// Front end of the Ricart-Agrawala node: accepts input words, decodes the
// operation and holds them in a two-entry queue for the back end. Uses rcag_pkg.
module rcag_front
   import rcag_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [1:0]     req_tuser,   // [1:0] op
   input  logic [23:0]    req_tdata,   // [15:0] req_seq, [19:16] req_node, [23:20] zero
   output queue_head_type head,
   input  logic           pop
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   new_item;

   // decode the incoming word
   always_comb begin
      new_item.op   = op_type'(req_tuser);
      new_item.seq  = req_tdata[SEQ_W-1:0];
      new_item.node = req_tdata[SEQ_W+NODE_W-1:SEQ_W];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* hw/rtl/rcag_back.sv */
// Back end of the Ricart-Agrawala node: protocol state, the deferred-node
// scan after a release, and the result output register. Uses rcag_pkg.
module rcag_back
   import rcag_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [NODE_W-1:0] my_node_id,
   input  queue_head_type    head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [1:0]        rsp_kind,
   output logic [SEQ_W-1:0]  rsp_seq,
   output logic [NODE_W-1:0] rsp_dest,
   output logic              rsp_last
);

   back_state_type     state_ff, state_in;
   logic               requesting_ff, requesting_in;
   logic [SEQ_W-1:0]   own_seq_ff, own_seq_in;
   logic [SEQ_W-1:0]   highest_ff, highest_in;
   logic [OUTST_W-1:0] outst_ff, outst_in;
   logic [NODES-1:0]   deferred_ff, deferred_in;
   logic [NODE_W-1:0]  scan_idx_ff, scan_idx_in;

   logic               out_valid_ff, out_valid_in;
   kind_type           out_kind_ff, out_kind_in;
   logic [SEQ_W-1:0]   out_seq_ff, out_seq_in;
   logic [NODE_W-1:0]  out_dest_ff, out_dest_in;
   logic               out_last_ff, out_last_in;

   logic               out_free;
   logic               load;
   logic               defer;
   logic [SEQ_W-1:0]   next_seq;
   logic [NODES-1:0]   later_mask;

   assign out_free = !out_valid_ff || rsp_tready;
   assign next_seq = (highest_ff == SEQ_MAX) ? SEQ_MAX : highest_ff + SEQ_W'(1);
   assign defer    = requesting_ff &&
                     ((head.item.seq > own_seq_ff) ||
                      ((head.item.seq == own_seq_ff) && (head.item.node > my_node_id)));

   // deferred nodes after the scan position that will still get a reply
   always_comb begin
      for (int j = 0; j < NODES; j++) begin
         later_mask[j] = deferred_ff[j] && (NODE_W'(j) > scan_idx_ff) &&
                         (NODE_W'(j) != my_node_id);
      end
   end

   // sequencer: execute queued words, then walk the deferred bits on release
   always_comb begin
      state_in      = state_ff;
      requesting_in = requesting_ff;
      own_seq_in    = own_seq_ff;
      highest_in    = highest_ff;
      outst_in      = outst_ff;
      deferred_in   = deferred_ff;
      scan_idx_in   = scan_idx_ff;
      pop           = 1'b0;
      load          = 1'b0;
      out_kind_in   = out_kind_ff;
      out_seq_in    = out_seq_ff;
      out_dest_in   = out_dest_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               case (head.item.op)
                  OP_LOCAL_REQ: begin
                     requesting_in = 1'b1;
                     own_seq_in    = next_seq;
                     outst_in      = OUTST_LOAD;
                     load          = 1'b1;
                     out_kind_in   = KIND_BCAST;
                     out_seq_in    = next_seq;
                     out_dest_in   = my_node_id;
                     out_last_in   = 1'b1;
                  end
                  OP_REMOTE_REQ: begin
                     if (head.item.seq > highest_ff) begin
                        highest_in = head.item.seq;
                     end
                     if (defer && (head.item.node != my_node_id) &&
                         (32'(head.item.node) < NODES)) begin
                        deferred_in[head.item.node] = 1'b1;
                     end else begin
                        load        = 1'b1;
                        out_kind_in = KIND_REPLY;
                        out_seq_in  = '0;
                        out_dest_in = head.item.node;
                        out_last_in = 1'b1;
                     end
                  end
                  OP_REMOTE_REP: begin
                     if (requesting_ff && (outst_ff != '0)) begin
                        outst_in = outst_ff - OUTST_W'(1);
                        if (outst_ff == OUTST_W'(1)) begin
                           load        = 1'b1;
                           out_kind_in = KIND_GRANT;
                           out_seq_in  = '0;
                           out_dest_in = my_node_id;
                           out_last_in = 1'b1;
                        end
                     end
                  end
                  OP_RELEASE: begin
                     requesting_in = 1'b0;
                     scan_idx_in   = '0;
                     state_in      = BK_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_SCAN: begin
            if (out_free) begin
               if (deferred_ff[scan_idx_ff]) begin
                  deferred_in[scan_idx_ff] = 1'b0;
                  if (scan_idx_ff != my_node_id) begin
                     load        = 1'b1;
                     out_kind_in = KIND_REPLY;
                     out_seq_in  = '0;
                     out_dest_in = scan_idx_ff;
                     out_last_in = (later_mask == '0);
                  end
               end
               scan_idx_in = scan_idx_ff + NODE_W'(1);
               if (scan_idx_ff == NODE_W'(NODES - 1)) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      out_valid_in = load || (out_valid_ff && !rsp_tready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         requesting_ff <= 1'b0;
         own_seq_ff    <= '0;
         highest_ff    <= '0;
         outst_ff      <= '0;
         deferred_ff   <= '0;
         scan_idx_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         requesting_ff <= requesting_in;
         own_seq_ff    <= own_seq_in;
         highest_ff    <= highest_in;
         outst_ff      <= outst_in;
         deferred_ff   <= deferred_in;
         scan_idx_ff   <= scan_idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (load) begin
         out_kind_ff <= out_kind_in;
         out_seq_ff  <= out_seq_in;
         out_dest_ff <= out_dest_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_seq    = out_seq_ff;
   assign rsp_dest   = out_dest_ff;
   assign rsp_last   = out_last_ff;

endmodule

/* hw/rtl/ricart_agrawala_node_core.sv */
// Top level of one Ricart-Agrawala mutual exclusion node: CSR port, front
// queue (rcag_front) and protocol back end (rcag_back). Uses rcag_pkg.
//
//   channel   dir   tdata / data                     tuser / other
//   req_      in    [15:0] req_seq, [19:16] req_node  [1:0] op
//   rsp_      out   [15:0] msg_seq, [19:16] dest_node [1:0] kind, tlast = last
//   csr_      in    0x0: my_node_id [3:0]             APB write/read, pready = 1
//
// The back end pops a local request, incoming request or reply and executes it
// when the result register is free. A release picks up the word, then walks
// the deferred bits one node per cycle; a stalled rsp_ holds the back end.
// Input words queue two deep, so the input side stalls only when that queue fills.
// Reset is synchronous and clears the control state, not queue or result data.
module ricart_agrawala_node_core
   import rcag_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // [15:0] req_seq, [19:16] req_node, [23:20] zero
   input  logic [1:0]  req_tuser,    // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [15:0] msg_seq, [19:16] dest_node, [23:20] zero
   output logic [1:0]  rsp_tuser,    // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [NODE_W-1:0] my_node_id_ff;
   queue_head_type    head;
   logic              pop;
   logic [SEQ_W-1:0]  rsp_seq;
   logic [NODE_W-1:0] rsp_dest;

   // configuration register at word 0
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         my_node_id_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         my_node_id_ff <= csr_pwdata[NODE_W-1:0];
      end
   end
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32-NODE_W){1'b0}}, my_node_id_ff};

   rcag_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .head       (head),
      .pop        (pop)
   );

   rcag_back u_back (
      .clock      (clock),
      .reset      (reset),
      .my_node_id (my_node_id_ff),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_seq    (rsp_seq),
      .rsp_dest   (rsp_dest),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, rsp_dest, rsp_seq};

endmodule

/* hw/rtl/rcag_checker.sv */
// Port-level checker for the Ricart-Agrawala node core, bound to the top level.
// Uses rcag_pkg for the result kind codes.
module rcag_checker
   import rcag_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a result word waiting on backpressure stays unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // no result carries the unused kind code
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_BCAST) || (rsp_tuser == KIND_REPLY) ||
      (rsp_tuser == KIND_GRANT))
      else $error("rsp kind out of range");

   // broadcasts and grants are single-word results
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_REPLY) |-> rsp_tlast)
      else $error("broadcast or grant without tlast");

   // a broadcast always carries a nonzero sequence number; others carry zero
   a_seq_field: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_BCAST) == (rsp_tdata[15:0] != 16'd0)))
      else $error("msg_seq inconsistent with kind");

endmodule

bind ricart_agrawala_node_core rcag_checker u_rcag_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
